// ===== rtl/adsc_pkg.sv =====
package adsc_pkg;

    localparam int DRIVE_MOTORS_DEF = 6;
    localparam int STEER_MOTORS_DEF = 4;
    localparam int ANGLE_LEVELS_DEF = 11;
    localparam int TABLE_COLS = 11;
    localparam int NUM_REGS = 6;
    localparam int NUM_RESULTS = 10;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_DRIVE = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [1:0] DIR_FWD   = 2'd1;
    localparam logic [1:0] DIR_REV   = 2'd2;
    localparam logic [1:0] DIR_BRAKE = 2'd3;

    localparam logic [2:0] REG_HOME_FL = 3'd0;
    localparam logic [2:0] REG_HOME_RL = 3'd1;
    localparam logic [2:0] REG_HOME_RR = 3'd2;
    localparam logic [2:0] REG_HOME_FR = 3'd3;
    localparam logic [2:0] REG_GAIN    = 3'd4;
    localparam logic [2:0] REG_SCALE   = 3'd5;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] throttle;
        logic [7:0] turn;
        logic [7:0] fb_front_left;
        logic [7:0] fb_rear_left;
        logic [7:0] fb_rear_right;
        logic [7:0] fb_front_right;
    } in_word_t;

    typedef struct packed {
        logic [3:0] motor_index;
        logic [7:0] pwm;
        logic [1:0] direction;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [7:0] pwm;
        logic [1:0] direction;
    } lane_res_t;

    function automatic logic [16:0] ratio_lut(input logic [2:0] m, input logic [3:0] c);
        logic [16:0] r;
        r = 17'd65536;
        unique case (m)
            3'd0: unique case (c)
                4'd0: r = 17'd29095; 4'd1: r = 17'd31058; 4'd2: r = 17'd34301;
                4'd3: r = 17'd39561; 4'd4: r = 17'd48494; 4'd6: r = 17'd63861;
                4'd7: r = 17'd64058; 4'd8: r = 17'd63980; 4'd9: r = 17'd64055;
                4'd10: r = 17'd64211; default: r = 17'd65536;
            endcase
            3'd1: unique case (c)
                4'd0: r = 17'd13782; 4'd1: r = 17'd19163; 4'd2: r = 17'd25535;
                4'd3: r = 17'd33745; 4'd4: r = 17'd45554; default: r = 17'd65536;
            endcase
            3'd2: unique case (c)
                4'd0: r = 17'd28150; 4'd1: r = 17'd30060; 4'd2: r = 17'd33334;
                4'd3: r = 17'd38730; 4'd4: r = 17'd47947; 4'd6: r = 17'd64411;
                4'd7: r = 17'd64910; 4'd8: r = 17'd64628; 4'd9: r = 17'd64397;
                4'd10: r = 17'd64267; default: r = 17'd65536;
            endcase
            3'd3: unique case (c)
                4'd0: r = 17'd64910; 4'd1: r = 17'd64628; 4'd2: r = 17'd64397;
                4'd3: r = 17'd64267; 4'd4: r = 17'd64411; 4'd6: r = 17'd28150;
                4'd7: r = 17'd30060; 4'd8: r = 17'd33334; 4'd9: r = 17'd38730;
                4'd10: r = 17'd47947; default: r = 17'd65536;
            endcase
            3'd4: unique case (c)
                4'd6: r = 17'd13782; 4'd7: r = 17'd19163; 4'd8: r = 17'd25535;
                4'd9: r = 17'd33745; 4'd10: r = 17'd45554; default: r = 17'd65536;
            endcase
            3'd5: unique case (c)
                4'd0: r = 17'd64211; 4'd1: r = 17'd64055; 4'd2: r = 17'd63980;
                4'd3: r = 17'd64058; 4'd4: r = 17'd63861; 4'd6: r = 17'd29095;
                4'd7: r = 17'd31058; 4'd8: r = 17'd34301; 4'd9: r = 17'd39561;
                4'd10: r = 17'd48494; default: r = 17'd65536;
            endcase
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] offset_lut(input logic [1:0] m,
                                                      input logic [3:0] a);
        logic signed [15:0] r;
        r = 16'sd0;
        unique case (m)
            2'd0: unique case (a)
                4'd0: r = -16'sd5078; 4'd1: r = -16'sd4543; 4'd2: r = -16'sd3907;
                4'd3: r = -16'sd3087; 4'd4: r = -16'sd1918; 4'd6: r = 16'sd12245;
                4'd7: r = 16'sd9849; 4'd8: r = 16'sd7442; 4'd9: r = 16'sd5008;
                4'd10: r = 16'sd2531; default: r = 16'sd0;
            endcase
            2'd1: unique case (a)
                4'd0: r = 16'sd4967; 4'd1: r = 16'sd4453; 4'd2: r = 16'sd3840;
                4'd3: r = 16'sd3045; 4'd4: r = 16'sd1901; 4'd6: r = -16'sd2560;
                4'd7: r = -16'sd5120; 4'd8: r = -16'sd7680; 4'd9: r = -16'sd10240;
                4'd10: r = -16'sd12800; default: r = 16'sd0;
            endcase
            2'd2: unique case (a)
                4'd0: r = 16'sd12800; 4'd1: r = 16'sd10240; 4'd2: r = 16'sd7680;
                4'd3: r = 16'sd5120; 4'd4: r = 16'sd2560; 4'd6: r = -16'sd1901;
                4'd7: r = -16'sd3045; 4'd8: r = -16'sd3840; 4'd9: r = -16'sd4453;
                4'd10: r = -16'sd4967; default: r = 16'sd0;
            endcase
            2'd3: unique case (a)
                4'd0: r = -16'sd12245; 4'd1: r = -16'sd9849; 4'd2: r = -16'sd7442;
                4'd3: r = -16'sd5008; 4'd4: r = -16'sd2531; 4'd6: r = 16'sd1918;
                4'd7: r = 16'sd3087; 4'd8: r = 16'sd3907; 4'd9: r = 16'sd4543;
                4'd10: r = 16'sd5078; default: r = 16'sd0;
            endcase
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ackermann_drive_steer_controller_core.sv =====
// channel | dir | word       | handshake
// in      | in  | in_word_t  | in_valid / in_ready
// out     | out | out_word_t | out_valid / out_ready
// cfg     | in  | 8-bit reg  | cfg_we, cfg_index, cfg_data
// one tick: accept cycle, then compute steps (lane multiply, error, gain multiply),
// then 10 output words, one per cycle when out_ready holds
// the six drive lanes and four steer lanes run side by side; a merge mux sends words
// out_ready low stalls the output register; the next tick waits until the last word
// reset clears state to speed 0, brake, angle 5 and registers to defaults
module ackermann_drive_steer_controller_core #(
    parameter int ANGLE_LEVELS = adsc_pkg::ANGLE_LEVELS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  adsc_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output adsc_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import adsc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;
    localparam logic [3:0] ANG_MAX = 4'(ANGLE_LEVELS - 1);

    logic [1:0] state_reg, state_next;
    logic [1:0] phase_reg;
    logic [3:0] idx_reg;
    logic [7:0] regs_reg [NUM_REGS];
    logic [7:0] speed_reg;
    logic [1:0] dir_reg;
    logic [3:0] ang_reg;
    logic       stop_reg;
    logic [7:0] fb_reg [4];
    logic [7:0] dpwm [6];
    lane_res_t  sres [4];
    logic [3:0] ang_c;
    logic [3:0] col;
    logic [8:0] s_fwd;
    logic [8:0] s_rev;
    logic [7:0] thr_rev;
    logic [15:0] q25_fwd;
    logic [15:0] q25_rev;
    logic [15:0] turn_m;
    logic [27:0] ang_prod;
    logic [3:0] ang_new;
    logic       acc;
    lane_res_t  sel;

    assign in_ready = (state_reg == ST_IDLE);
    assign acc = in_valid && in_ready;
    assign ang_c = (ang_reg > 4'(TABLE_COLS - 1)) ? 4'(TABLE_COLS - 1) : ang_reg;
    assign col = 4'(TABLE_COLS - 1) - ang_c;

    // 255 * t / 125 is 2t + t / 25, and t / 25 is (t * 41) >> 10 for t below 256
    assign thr_rev = in_word.throttle - 8'd125;
    assign q25_fwd = 16'(in_word.throttle) * 16'd41;
    assign q25_rev = 16'(thr_rev) * 16'd41;
    assign s_fwd = {in_word.throttle, 1'b0} + 9'(q25_fwd[15:10]);
    assign s_rev = {thr_rev, 1'b0} + 9'(q25_rev[15:10]);
    assign turn_m = 16'(in_word.turn) * 16'(ANGLE_LEVELS - 1);
    // divide by 250 as a reciprocal multiply
    assign ang_prod = 28'(turn_m) * 28'd4195;

    always_comb
    begin
        logic [15:0] q;
        q = 16'(ang_prod[27:20]);
        if (q > 16'(ANG_MAX))
            q = 16'(ANG_MAX);
        if (q > 16'(TABLE_COLS - 1))
            q = 16'(TABLE_COLS - 1);
        ang_new = q[3:0];
    end

    genvar g;
    generate
        for (g = 0; g < 6; g++)
        begin : g_drive
            adsc_drive_lane u_lane (
                .clk   (clk),
                .motor (3'(g)),
                .col   (col),
                .speed (speed_reg),
                .start (state_reg == ST_CALC && phase_reg == 2'd1),
                .pwm   (dpwm[g])
            );
        end
        for (g = 0; g < 4; g++)
        begin : g_steer
            adsc_steer_lane u_lane (
                .clk   (clk),
                .motor (2'(g)),
                .ang   (ang_c),
                .home  (regs_reg[g]),
                .scale (regs_reg[REG_SCALE]),
                .gain  (regs_reg[REG_GAIN]),
                .fb    (fb_reg[g]),
                .phase ((state_reg == ST_CALC) ? phase_reg : 2'd0),
                .res   (sres[g])
            );
        end
    endgenerate

    always_comb
    begin
        sel.pwm = 8'd0;
        sel.direction = dir_reg;
        if (idx_reg < 4'd6)
            sel.pwm = dpwm[idx_reg[2:0]];
        else
            sel = sres[2'(idx_reg - 4'd6)];
        out_word.motor_index = idx_reg;
        out_word.pwm = sel.pwm;
        out_word.direction = stop_reg ? DIR_BRAKE : sel.direction;
        out_word.last = (idx_reg == 4'(NUM_RESULTS - 1));
    end

    assign out_valid = (state_reg == ST_SEND);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (acc) state_next = ST_CALC;
            ST_CALC: if (phase_reg == 2'd3) state_next = ST_SEND;
            ST_SEND: if (out_ready && out_word.last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 2'd0;
            idx_reg   <= 4'd0;
            speed_reg <= 8'd0;
            dir_reg   <= DIR_BRAKE;
            ang_reg   <= 4'd5;
            stop_reg  <= 1'b0;
            regs_reg[0] <= 8'd128;
            regs_reg[1] <= 8'd128;
            regs_reg[2] <= 8'd128;
            regs_reg[3] <= 8'd128;
            regs_reg[4] <= 8'd64;
            regs_reg[5] <= 8'd16;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index < 3'(NUM_REGS))
                regs_reg[cfg_index] <= cfg_data;
            if (acc)
            begin
                phase_reg <= 2'd1;
                idx_reg <= 4'd0;
                if (in_word.cmd == CMD_DRIVE)
                begin
                    if (in_word.throttle <= 8'd125)
                    begin
                        speed_reg <= s_fwd[7:0];
                        dir_reg <= DIR_FWD;
                    end
                    else
                    begin
                        speed_reg <= s_rev[8] ? 8'd255 : s_rev[7:0];
                        dir_reg <= DIR_REV;
                    end
                    ang_reg <= ang_new;
                end
                else if (in_word.cmd == CMD_STOP)
                begin
                    dir_reg <= DIR_BRAKE;
                    stop_reg <= 1'b1;
                end
            end
            else if (state_reg == ST_CALC)
                phase_reg <= phase_reg + 2'd1;
            if (state_reg == ST_SEND && out_ready)
                idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fb_reg[0] <= in_word.fb_front_left;
            fb_reg[1] <= in_word.fb_rear_left;
            fb_reg[2] <= in_word.fb_rear_right;
            fb_reg[3] <= in_word.fb_front_right;
        end
    end
endmodule

// ===== rtl/adsc_drive_lane.sv =====
module adsc_drive_lane (
    input  logic                  clk,
    input  logic [2:0]            motor,
    input  logic [3:0]            col,
    input  logic [7:0]            speed,
    input  logic                  start,
    output logic [7:0]            pwm
);
    import adsc_pkg::*;

    logic [24:0] prod_reg;
    logic [24:0] prod_next;

    assign prod_next = ratio_lut(motor, col) * speed;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        if (prod_reg <= 25'(50 << 16))
            pwm = 8'd0;
        else if (prod_reg[24])
            pwm = 8'd255;
        else
            pwm = prod_reg[23:16];
    end
endmodule

// ===== rtl/adsc_steer_lane.sv =====
module adsc_steer_lane (
    input  logic                  clk,
    input  logic [1:0]            motor,
    input  logic [3:0]            ang,
    input  logic [7:0]            home,
    input  logic [7:0]            scale,
    input  logic [7:0]            gain,
    input  logic [7:0]            fb,
    input  logic [1:0]            phase,
    output adsc_pkg::lane_res_t   res
);
    import adsc_pkg::*;

    logic signed [24:0] x_reg;
    logic signed [24:0] x_next;
    logic signed [13:0] err_reg;
    logic signed [13:0] err_next;
    logic signed [22:0] p_reg;
    logic signed [22:0] p_next;
    logic signed [12:0] target;
    logic [21:0]        mag;
    logic [20:0]        xmag;

    assign x_next = $signed({1'b0, home, 12'd0})
                  + $signed({1'b0, scale}) * offset_lut(motor, ang);
    assign xmag   = x_reg[24] ? 21'((-x_reg) >>> 12) : 21'(x_reg >>> 12);
    assign target = x_reg[24] ? -$signed(13'(xmag)) : $signed(13'(xmag));
    assign err_next = 14'(target) - $signed({6'd0, fb});
    assign p_next = $signed({1'b0, gain}) * err_reg;
    assign mag = p_reg[22] ? 22'((-p_reg) >>> 4) : 22'(p_reg >>> 4);

    always_ff @(posedge clk)
    begin
        if (phase == 2'd1)
            x_reg <= x_next;
        if (phase == 2'd2)
            err_reg <= err_next;
        if (phase == 2'd3)
            p_reg <= p_next;
    end

    always_comb
    begin
        res.direction = (p_reg[22] && mag != 22'd0) ? DIR_REV : DIR_FWD;
        if (mag >= 22'd255)
            res.pwm = 8'd254;
        else if (mag < 22'd10)
            res.pwm = 8'd0;
        else
            res.pwm = mag[7:0];
    end
endmodule

// ===== rtl/adsc_checker.sv =====
module adsc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input adsc_pkg::out_word_t out_word
);
    import adsc_pkg::*;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.motor_index <= 4'd9) else $error("bad index");
    a_dir_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.direction != 2'd0) else $error("bad direction");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output dropped");
endmodule

bind ackermann_drive_steer_controller_core adsc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);

// ===== sim/tb_top.sv =====
module tb_top;
    import adsc_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_word;
    logic out_valid;
    logic out_ready;
    out_word_t out_word;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    ackermann_drive_steer_controller_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // drive ratios in q1.16, rows are motors, columns run from angle level 10 down to 0
    localparam logic [16:0] SPEED_RATIO [6][11] = '{
        '{17'd29095, 17'd31058, 17'd34301, 17'd39561, 17'd48494, 17'd65536,
          17'd63861, 17'd64058, 17'd63980, 17'd64055, 17'd64211},
        '{17'd13782, 17'd19163, 17'd25535, 17'd33745, 17'd45554, 17'd65536,
          17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536},
        '{17'd28150, 17'd30060, 17'd33334, 17'd38730, 17'd47947, 17'd65536,
          17'd64411, 17'd64910, 17'd64628, 17'd64397, 17'd64267},
        '{17'd64910, 17'd64628, 17'd64397, 17'd64267, 17'd64411, 17'd65536,
          17'd28150, 17'd30060, 17'd33334, 17'd38730, 17'd47947},
        '{17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
          17'd13782, 17'd19163, 17'd25535, 17'd33745, 17'd45554},
        '{17'd64211, 17'd64055, 17'd63980, 17'd64058, 17'd63861, 17'd65536,
          17'd29095, 17'd31058, 17'd34301, 17'd39561, 17'd48494}
    };

    // ackermann offsets in q8.8
    localparam int STEER_OFFSET [4][11] = '{
        '{-5078, -4543, -3907, -3087, -1918, 0, 12245, 9849, 7442, 5008, 2531},
        '{4967, 4453, 3840, 3045, 1901, 0, -2560, -5120, -7680, -10240, -12800},
        '{12800, 10240, 7680, 5120, 2560, 0, -1901, -3045, -3840, -4453, -4967},
        '{-12245, -9849, -7442, -5008, -2531, 0, 1918, 3087, 3907, 4543, 5078}
    };

    logic [7:0] ctrl_regs [NUM_REGS];
    logic [7:0] exp_speed;
    logic [1:0] drive_dir;
    logic [3:0] exp_angle;
    logic stopped;

    out_word_t expected_words[$];
    int mismatches;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    bit timed_out;

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    task automatic predict_tick(input in_word_t w);
        logic [8:0] s;
        int ang;
        int col;
        longint prod;
        longint x;
        longint target;
        longint p;
        longint mag;
        logic [7:0] fb;
        logic [7:0] pwm;
        logic [1:0] dir;
        out_word_t r;
        if (w.cmd == CMD_DRIVE)
        begin
            if (w.throttle <= 125)
            begin
                s = 9'((255 * w.throttle) / 125);
                drive_dir = DIR_FWD;
            end
            else
            begin
                s = 9'((255 * (w.throttle - 125)) / 125);
                drive_dir = DIR_REV;
            end
            exp_speed = (s > 255) ? 8'd255 : s[7:0];
            ang = (w.turn * 10) / 250;
            if (ang > 10)
                ang = 10;
            exp_angle = ang[3:0];
        end
        else if (w.cmd == CMD_STOP)
        begin
            drive_dir = DIR_BRAKE;
            stopped = 1'b1;
        end
        ang = exp_angle;
        col = 10 - ang;
        for (int i = 0; i < 6; i++)
        begin
            prod = longint'(SPEED_RATIO[i][col]) * exp_speed;
            mag = (prod > (50 << 16)) ? (prod >> 16) : 0;
            if (mag > 255)
                mag = 255;
            r.motor_index = i[3:0];
            r.pwm = mag[7:0];
            r.direction = stopped ? DIR_BRAKE : drive_dir;
            r.last = 1'b0;
            expected_words.push_back(r);
        end
        for (int i = 0; i < 4; i++)
        begin
            case (i)
                0: fb = w.fb_front_left;
                1: fb = w.fb_rear_left;
                2: fb = w.fb_rear_right;
                default: fb = w.fb_front_right;
            endcase
            x = longint'(ctrl_regs[i]) * 4096
                + longint'(ctrl_regs[REG_SCALE]) * STEER_OFFSET[i][ang];
            target = (x >= 0) ? (x >>> 12) : -((-x) >>> 12);
            p = longint'(ctrl_regs[REG_GAIN]) * (target - fb);
            if (p >= 0)
            begin
                mag = p >>> 4;
                dir = DIR_FWD;
            end
            else
            begin
                mag = (-p) >>> 4;
                dir = (mag == 0) ? DIR_FWD : DIR_REV;
            end
            pwm = (mag >= 255) ? 8'd254 : mag[7:0];
            if (pwm < 10)
                pwm = 8'd0;
            r.motor_index = 4'(6 + i);
            r.pwm = pwm;
            r.direction = stopped ? DIR_BRAKE : dir;
            r.last = (i == 3);
            expected_words.push_back(r);
        end
    endtask

    task automatic send_tick(input in_word_t w);
        while (($urandom_range(99) < send_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_tick(w);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        ctrl_regs[idx] = val;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic in_word_t random_tick(input int drive_pct);
        in_word_t w;
        int pick;
        pick = $urandom_range(99);
        if (pick < drive_pct)
            w.cmd = CMD_DRIVE;
        else if (pick < 97)
            w.cmd = ($urandom_range(1) == 0) ? CMD_TICK : CMD_UNUSED;
        else
            w.cmd = CMD_STOP;
        w.throttle = 8'($urandom_range(255));
        w.turn = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(250));
        w.fb_front_left = 8'($urandom_range(255));
        w.fb_rear_left = 8'($urandom_range(255));
        w.fb_rear_right = 8'($urandom_range(255));
        w.fb_front_right = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic in_word_t make_tick(input logic [1:0] c, input logic [7:0] thr,
                                           input logic [7:0] trn, input logic [7:0] fb);
        in_word_t w;
        w.cmd = c;
        w.throttle = thr;
        w.turn = trn;
        w.fb_front_left = fb;
        w.fb_rear_left = ~fb;
        w.fb_rear_right = fb ^ 8'h5a;
        w.fb_front_right = fb + 8'd37;
        return w;
    endfunction

    task automatic test_directed_drive();
        send_tick(make_tick(CMD_TICK, 8'd0, 8'd0, 8'd128));
        send_tick(make_tick(CMD_DRIVE, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(CMD_DRIVE, 8'd125, 8'd250, 8'd255));
        send_tick(make_tick(CMD_DRIVE, 8'd126, 8'd125, 8'd128));
        send_tick(make_tick(CMD_DRIVE, 8'd250, 8'd0, 8'd64));
        send_tick(make_tick(CMD_DRIVE, 8'd255, 8'd255, 8'd200));
        send_tick(make_tick(CMD_DRIVE, 8'd25, 8'd100, 8'd130));
        send_tick(make_tick(CMD_DRIVE, 8'd26, 8'd24, 8'd127));
        send_tick(make_tick(CMD_UNUSED, 8'hff, 8'hff, 8'haa));
        send_tick(make_tick(CMD_DRIVE, 8'd200, 8'd175, 8'h55));
        for (int a = 0; a <= 250; a += 25)
            send_tick(make_tick(CMD_DRIVE, 8'd100, 8'(a), 8'(a)));
    endtask

    task automatic test_registers(input int n);
        wait_drained();
        for (int r = 0; r < NUM_REGS; r++)
        begin
            case ($urandom_range(3))
                0: write_reg(3'(r), 8'd0);
                1: write_reg(3'(r), 8'd255);
                default: write_reg(3'(r), 8'($urandom_range(255)));
            endcase
        end
        for (int i = 0; i < n; i++)
            send_tick(random_tick(60));
    endtask

    task automatic test_back_pressure();
        wait_drained();
        hold_off_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_tick(random_tick(70));
    endtask

    task automatic test_stop();
        send_tick(make_tick(CMD_STOP, 8'd100, 8'd0, 8'd0));
        send_tick(make_tick(CMD_DRIVE, 8'd50, 8'd200, 8'd90));
        for (int i = 0; i < 30; i++)
            send_tick(random_tick(60));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", out_word);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (out_word !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_w, out_word);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_off_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ctrl_regs = '{8'd128, 8'd128, 8'd128, 8'd128, 8'd64, 8'd16};
        exp_speed = 8'd0;
        drive_dir = DIR_BRAKE;
        exp_angle = 4'd5;
        stopped = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_drive();
        test_registers(80);
        send_idle_pct = 66;
        test_registers(80);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        test_registers(80);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        test_registers(80);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_back_pressure();
        wait_drained();
        write_reg(REG_GAIN, 8'd16);
        write_reg(REG_SCALE, 8'd16);
        for (int i = 0; i < 80; i++)
            send_tick(random_tick(60));
        test_stop();
        wait_drained();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== ackermann_drive_steer_controller_core.f =====
rtl/adsc_pkg.sv
rtl/adsc_drive_lane.sv
rtl/adsc_steer_lane.sv
rtl/ackermann_drive_steer_controller_core.sv
rtl/adsc_checker.sv
sim/tb_top.sv
